FILE: hdl/dcc_pkg.sv
package dcc_pkg;

    localparam int unsigned COLOR_W = 32;
    localparam int unsigned SLOT_W  = 8;
    localparam int unsigned CNT_W   = 9;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               restart;
    } item_t;

    typedef struct packed {
        logic              is_new;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  distinct_count;
        logic              full_res;
    } res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FINISH
    } state_t;

endpackage

FILE: hdl/dcc_table.sv
module dcc_table #(
    parameter int unsigned DEPTH  = 256,
    parameter int unsigned ADDR_W = 8
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [ADDR_W-1:0]            wr_addr,
    input  logic [dcc_pkg::COLOR_W-1:0]  wr_data,
    input  logic                         rd_en,
    input  logic [ADDR_W-1:0]            rd_addr,
    output logic [dcc_pkg::COLOR_W-1:0]  rd_data
);

    // color storage, one write and one registered read port
    logic [dcc_pkg::COLOR_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hdl/distinct_color_collector_core.sv
// distinct color collector
// keeps a table of the distinct 32-bit colors seen since reset or restart
// input channel: item_valid / item_ready, payload item (color, restart)
// output channel: res_valid / res_ready, payload res (is_new, slot,
//   distinct_count, full_res), exactly one result per input transfer
// restart set on an item empties the set before that color is handled
// an item's time from its transfer to its result grows with the number of
//   recorded entries, and is shorter on an early match; the cost is set
//   by the linear search: one table read and one 32-bit compare per cycle
//   through the single read port of the color memory
// after each result the sequencer passes through its idle step, so it takes
//   no new item before it is through with the last one
// item_ready is high only while the sequencer is idle
// the result sits in an output register; the next item is taken while it
//   waits, and the sequencer holds in its last step if the register is
//   still occupied when the next result is ready
// reset empties the set and clears the result valid flag; the color memory
//   itself is not cleared, only entries below the count are ever read
module distinct_color_collector_core #(
    parameter int unsigned TABLE_DEPTH = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_ready,
    input  dcc_pkg::item_t item,
    output logic           res_valid,
    input  logic           res_ready,
    output dcc_pkg::res_t  res
);

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    // sequencer state
    dcc_pkg::state_t state_reg, state_next;

    // search control
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] rd_addr_reg, rd_addr_next;
    logic          cmp_pend_reg, cmp_pend_next;
    logic [AW-1:0] cmp_idx_reg, cmp_idx_next;
    logic          found_reg, found_next;
    logic [AW-1:0] found_idx_reg, found_idx_next;
    logic [dcc_pkg::COLOR_W-1:0] color_reg, color_next;

    // result register
    logic          res_valid_reg, res_valid_next;
    dcc_pkg::res_t res_reg, res_next;

    // shared datapath signals
    logic                        issue;
    logic                        hit;
    logic                        out_free;
    logic                        finish_go;
    logic                        room;
    logic                        wr_en;
    logic [dcc_pkg::COLOR_W-1:0] rd_data;

    dcc_table #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (AW)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (color_reg),
        .rd_en   (issue),
        .rd_addr (rd_addr_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    // control outputs of the sequencer
    always_comb
    begin
        item_ready = (state_reg == dcc_pkg::ST_IDLE);
        // one read issued per cycle while unread entries remain
        issue      = (state_reg == dcc_pkg::ST_SEARCH) && (rd_addr_reg < count_reg);
        // the single compare unit checks the entry read last cycle
        hit        = (state_reg == dcc_pkg::ST_SEARCH) && cmp_pend_reg
                     && (rd_data == color_reg);
        out_free   = !res_valid_reg || res_ready;
        finish_go  = (state_reg == dcc_pkg::ST_FINISH) && out_free;
        room       = (count_reg < CW'(TABLE_DEPTH));
        wr_en      = finish_go && !found_reg && room;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dcc_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = dcc_pkg::ST_SEARCH;
                end
            end
            dcc_pkg::ST_SEARCH:
            begin
                // done on a match, or once every recorded entry was compared
                if (hit || (!issue && !cmp_pend_reg))
                begin
                    state_next = dcc_pkg::ST_FINISH;
                end
            end
            dcc_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = dcc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dcc_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        count_next     = count_reg;
        rd_addr_next   = rd_addr_reg;
        cmp_pend_next  = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        found_next     = found_reg;
        found_idx_next = found_idx_reg;
        color_next     = color_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !res_ready;

        if (item_valid && item_ready)
        begin
            color_next   = item.color;
            rd_addr_next = '0;
            found_next   = 1'b0;
            if (item.restart)
            begin
                count_next = '0;
            end
        end

        if (state_reg == dcc_pkg::ST_SEARCH)
        begin
            cmp_pend_next = issue;
            if (issue)
            begin
                cmp_idx_next = rd_addr_reg[AW-1:0];
                rd_addr_next = rd_addr_reg + CW'(1);
            end
            if (hit)
            begin
                found_next     = 1'b1;
                found_idx_next = cmp_idx_reg;
            end
        end

        if (finish_go)
        begin
            res_valid_next          = 1'b1;
            res_next.is_new         = !found_reg && room;
            res_next.full_res       = !found_reg && !room;
            if (found_reg)
            begin
                res_next.slot = dcc_pkg::SLOT_W'(found_idx_reg);
            end
            else if (room)
            begin
                res_next.slot = dcc_pkg::SLOT_W'(count_reg[AW-1:0]);
            end
            else
            begin
                res_next.slot = '0;
            end
            if (wr_en)
            begin
                count_next = count_reg + CW'(1);
            end
            res_next.distinct_count = dcc_pkg::CNT_W'(count_next);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dcc_pkg::ST_IDLE;
            count_reg     <= '0;
            rd_addr_reg   <= '0;
            cmp_pend_reg  <= 1'b0;
            found_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_addr_reg   <= rd_addr_next;
            cmp_pend_reg  <= cmp_pend_next;
            found_reg     <= found_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        color_reg     <= color_next;
        cmp_idx_reg   <= cmp_idx_next;
        found_idx_reg <= found_idx_next;
        res_reg       <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

`ifndef SYNTHESIS
    // the count never passes the table depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("entry count above table depth");

    // a result only appears from the finish step
    a_res_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg) == dcc_pkg::ST_FINISH)
        else $error("result raised outside finish step");

    // a match ends the search
    a_hit_ends: assert property (@(posedge clk) disable iff (!rst_n)
        hit |=> (state_reg == dcc_pkg::ST_FINISH) && found_reg)
        else $error("match did not end the search");

    // an append raises the count by one
    a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> count_reg == $past(count_reg) + CW'(1))
        else $error("append did not raise the count");

    // reads never go past the table depth
    a_read_bound: assert property (@(posedge clk) disable iff (!rst_n)
        issue |-> rd_addr_reg < CW'(TABLE_DEPTH))
        else $error("read beyond table");
`endif

endmodule

FILE: verif/color_set_checker.sv
`timescale 1ns / 100ps

module color_set_checker #(
    parameter int unsigned TABLE_DEPTH = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    input  logic           item_ready,
    input  dcc_pkg::item_t item,
    input  logic           res_valid,
    input  logic           res_ready,
    input  dcc_pkg::res_t  res,
    output int             n_errors,
    output int             n_pending
);

    // predicted color set
    logic [dcc_pkg::COLOR_W-1:0] known_colors [TABLE_DEPTH];
    int unsigned                 known_count;

    // results owed by the block, oldest first
    dcc_pkg::res_t               owed_results [$];
    dcc_pkg::res_t               want;

    function automatic dcc_pkg::res_t collect_color(input dcc_pkg::item_t px);
        dcc_pkg::res_t r;
        int unsigned   k;
        bit            hit;
        r   = '0;
        hit = 1'b0;
        if (px.restart)
            known_count = 0;
        for (k = 0; k < known_count; k++)
        begin
            if (known_colors[k] == px.color)
            begin
                hit    = 1'b1;
                r.slot = k[dcc_pkg::SLOT_W-1:0];
                break;
            end
        end
        if (!hit)
        begin
            if (known_count < TABLE_DEPTH)
            begin
                known_colors[known_count] = px.color;
                r.slot      = known_count[dcc_pkg::SLOT_W-1:0];
                r.is_new    = 1'b1;
                known_count = known_count + 1;
            end
            else
            begin
                // set full, color dropped
                r.full_res = 1'b1;
            end
        end
        r.distinct_count = known_count[dcc_pkg::CNT_W-1:0];
        return r;
    endfunction

    task automatic log_failure(input string what, input dcc_pkg::res_t exp_r,
                               input dcc_pkg::res_t got_r);
        n_errors++;
        if (n_errors <= 10)
            $display("%0t %s: is_new %0b/%0b slot %0d/%0d count %0d/%0d full %0b/%0b (exp/got)",
                     $realtime, what, exp_r.is_new, got_r.is_new, exp_r.slot, got_r.slot,
                     exp_r.distinct_count, got_r.distinct_count,
                     exp_r.full_res, got_r.full_res);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            known_count = 0;
            n_errors    = 0;
            owed_results.delete();
            n_pending <= 0;
        end
        else
        begin
            if (item_valid && item_ready)
                owed_results.push_back(collect_color(item));
            if (res_valid && res_ready)
            begin
                if (owed_results.size() == 0)
                    log_failure("unexpected result", '0, res);
                else
                begin
                    want = owed_results.pop_front();
                    if (res.is_new !== want.is_new || res.slot !== want.slot ||
                        res.distinct_count !== want.distinct_count ||
                        res.full_res !== want.full_res)
                        log_failure("result mismatch", want, res);
                end
            end
            n_pending <= owed_results.size();
        end
    end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int unsigned TABLE_DEPTH = 256;
    // stimulus stops once about this many pixels went in
    localparam int unsigned ITEM_TARGET = 950;
    // a full search, the longest receiver stalls and the longest sender gaps
    // all stay far below this; it is many times the longest quiet stretch
    localparam int unsigned QUIET_LIMIT = 20000;
    localparam int unsigned FILL_LEN    = TABLE_DEPTH + TABLE_DEPTH / 2 + 20;

    logic           clk;
    logic           rst_n;
    logic           item_valid;
    logic           item_ready;
    dcc_pkg::item_t item;
    logic           res_valid;
    logic           res_ready;
    dcc_pkg::res_t  res;

    int             n_errors;
    int             n_pending;
    int unsigned    pixels_sent;
    int unsigned    quiet_cycles;
    // when set the sender puts pixels back to back
    bit             steady;

    distinct_color_collector_core #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // watches both channels, predicts every result and compares
    color_set_checker #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .n_errors   (n_errors),
        .n_pending  (n_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // color sources
    // ------------------------------------------------------------------

    // mostly full-range random, with all-zero, all-one and walking-one
    // colors mixed in so the edges of the compare get hit often
    function automatic logic [31:0] random_color();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return 32'h0000_0000;
        if (r < 8)
            return 32'hFFFF_FFFF;
        if (r < 12)
            return 32'h1 << $urandom_range(0, 31);
        return $urandom;
    endfunction

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    // one pixel transfer; valid stays up across back-to-back pixels and
    // only drops when a gap follows
    task automatic push_pixel(input logic [31:0] c, input logic rs);
        int unsigned gap;
        int unsigned r;
        item_valid   <= 1'b1;
        item.color   <= c;
        item.restart <= rs;
        do
        begin
            @(posedge clk);
        end
        while (!item_ready);
        pixels_sent++;
        // gaps: mostly none or short, now and then a long one
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            gap = 0;
        else if (r < 94)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 40);
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold the sender until every owed result has been taken; the count
    // from the checker is registered, so wait on the clock before the first look
    task automatic drain_results();
        item_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (n_pending != 0);
    endtask

    // restart, then run the set past full: mostly new colors with hits on
    // recorded ones, so the tail sees dropped colors and hits in a full set
    task automatic fill_phase();
        logic [31:0] seen [$];
        logic [31:0] c;
        int unsigned i;
        for (i = 0; i < FILL_LEN; i++)
        begin
            if (i == 0 || $urandom_range(0, 99) < 80)
            begin
                c = random_color();
                seen.push_back(c);
                push_pixel(c, i == 0);
            end
            else
                push_pixel(seen[$urandom_range(0, seen.size() - 1)], 1'b0);
        end
    endtask

    // short run over a small palette: lots of hits, occasional restart,
    // some pure noise pixels
    task automatic palette_phase();
        logic [31:0] palette [$];
        int unsigned n;
        int unsigned i;
        int unsigned r;
        bit          lead_restart;
        n = $urandom_range(1, 16);
        for (i = 0; i < n; i++)
            palette.push_back(random_color());
        lead_restart = ($urandom_range(0, 99) < 70);
        n = $urandom_range(10, 60);
        for (i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
                push_pixel($urandom, $urandom_range(0, 99) < 20);
            else
                push_pixel(palette[$urandom_range(0, palette.size() - 1)],
                           (i == 0 && lead_restart) || r < 13);
        end
    endtask

    // ------------------------------------------------------------------
    // output side: ready in stretches, mostly short stalls, few long ones,
    // and sometimes a long run with no stall at all
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned r;
        res_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            r = $urandom_range(0, 99);
            if (r < 50)
            begin
                res_ready <= 1'b1;
                repeat ($urandom_range(0, 19)) @(posedge clk);
            end
            else if (r < 92)
            begin
                res_ready <= 1'b0;
                repeat ($urandom_range(0, 2)) @(posedge clk);
            end
            else if (r < 97)
            begin
                res_ready <= 1'b0;
                repeat ($urandom_range(20, 60)) @(posedge clk);
            end
            else
            begin
                res_ready <= 1'b1;
                repeat ($urandom_range(100, 300)) @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long without any transfer on either channel
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (res_valid && res_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n        <= 1'b0;
        item_valid   <= 1'b0;
        item         <= '0;
        pixels_sent  = 0;
        steady       = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // color 0 is recorded like any other, then hit
        push_pixel(32'h0000_0000, 1'b0);
        push_pixel(32'h0000_0000, 1'b0);
        push_pixel(32'hFFFF_FFFF, 1'b0);
        push_pixel(32'h8000_0000, 1'b0);
        push_pixel(32'h0000_0001, 1'b0);
        push_pixel(32'h7FFF_FFFF, 1'b0);
        push_pixel(32'hFFFF_FFFF, 1'b0);
        push_pixel(32'h0000_0000, 1'b0);
        push_pixel(32'h7FFF_FFFF, 1'b0);
        // restart: color lands in slot 0 of the emptied set
        push_pixel(32'hA5A5_A5A5, 1'b1);
        // stale entries past the count must not match
        push_pixel(32'h8000_0000, 1'b0);
        push_pixel(32'h0000_0001, 1'b0);
        push_pixel(32'hA5A5_A5A5, 1'b0);
        // restart with the color already in slot 0
        push_pixel(32'hA5A5_A5A5, 1'b1);
        push_pixel(32'h5A5A_5A5A, 1'b0);
        // back-to-back restarts
        push_pixel(32'h0000_0000, 1'b1);
        push_pixel(32'h0000_0000, 1'b1);
        push_pixel(32'hFFFF_FFFF, 1'b0);

        // let the block run dry once before the random part
        drain_results();

        // the first random phase always fills the set
        fill_phase();
        while (pixels_sent < ITEM_TARGET)
        begin
            steady = ($urandom_range(0, 99) < 25);
            if (pixels_sent + FILL_LEN < ITEM_TARGET && $urandom_range(0, 99) < 15)
                fill_phase();
            else
                palette_phase();
            if ($urandom_range(0, 99) < 30)
                drain_results();
        end

        drain_results();
        // anything late or extra shows up here
        repeat (TABLE_DEPTH + 8) @(posedge clk);
        if (n_errors == 0 && n_pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
